// ===== design/gsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsbp_pkg
// Shared types, sizes and opcode codes for the gshare / BTB branch predictor.
// ----------------------------------------------------------------------------
package gsbp_pkg;

    // table sizes
    localparam int COUNTER_ENTRIES = 256;
    localparam int TARGET_ENTRIES  = 1024;
    localparam int HISTORY_BITS    = 8;

    localparam int CTR_IDX_W = $clog2(COUNTER_ENTRIES);
    localparam int TGT_IDX_W = $clog2(TARGET_ENTRIES);

    // the clearing sweep covers the larger of the two tables
    localparam int CLEAR_ENTRIES =
        (COUNTER_ENTRIES > TARGET_ENTRIES) ? COUNTER_ENTRIES : TARGET_ENTRIES;
    localparam int CLR_W = $clog2(CLEAR_ENTRIES);

    // item kinds
    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    // branch opcodes
    localparam logic [10:0] OP_CBZ   = 11'h0B4;
    localparam logic [10:0] OP_CBNZ  = 11'h0B5;
    localparam logic [10:0] OP_BCOND = 11'h054;
    localparam logic [10:0] OP_B     = 11'h005;
    localparam logic [10:0] OP_BR    = 11'h6B0;

    // 2-bit direction counter codes
    typedef logic [1:0] t_ctr;
    localparam t_ctr CTR_STRONG_NOT   = 2'd0;
    localparam t_ctr CTR_STRONG_TAKEN = 2'd3;

    // input item
    typedef struct packed {
        logic        kind;
        logic [63:0] pc;
        logic [63:0] actual_next_pc;
        logic        branch_taken;
        logic [10:0] opcode;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [63:0] next_pc;
        logic        btb_miss;
    } t_out_item;

    // one target buffer entry
    typedef struct packed {
        logic        valid;
        logic [63:0] tag;
        logic        is_cond;
        logic [63:0] target;
    } t_btb_entry;

    // write-back requests from the resolve logic
    typedef struct packed {
        logic       btb_we;
        t_btb_entry btb_wdata;
        logic       ctr_we;
        t_ctr       ctr_wdata;
        logic       hist_shift;
        logic       hist_bit;
    } t_update;

    function automatic logic is_cond_op(input logic [10:0] op);
        return (op == OP_CBZ) || (op == OP_CBNZ) || (op == OP_BCOND);
    endfunction

    function automatic logic is_branch_op(input logic [10:0] op);
        return is_cond_op(op) || (op == OP_B) || (op == OP_BR);
    endfunction

endpackage

// ===== design/gsbp_ram.sv =====
// ----------------------------------------------------------------------------
// gsbp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gsbp_resolve.sv =====
// ----------------------------------------------------------------------------
// gsbp_resolve
// Forms the prediction and the write-back values from the entries read.
// ----------------------------------------------------------------------------
module gsbp_resolve
    import gsbp_pkg::*;
(
    input  t_in_item   i_item,
    input  t_btb_entry i_entry,
    input  t_ctr       i_ctr,
    output t_out_item  o_result,
    output t_update    o_update
);

    logic        hit;
    logic [63:0] seq_pc;
    logic        cond;
    t_ctr        ctr_next;

    assign seq_pc = i_item.pc + 64'd4;
    assign hit    = i_entry.valid && (i_entry.tag == i_item.pc);
    assign cond   = is_cond_op(i_item.opcode);

    // prediction: counter msb set means weakly or strongly taken
    always_comb begin
        o_result.btb_miss = !hit;
        if (hit && (!i_entry.is_cond || i_ctr[1])) begin
            o_result.next_pc = i_entry.target;
        end else begin
            o_result.next_pc = seq_pc;
        end
    end

    // saturating counter step
    always_comb begin
        ctr_next = i_ctr;
        if (i_item.branch_taken) begin
            if (i_ctr != CTR_STRONG_TAKEN) begin
                ctr_next = i_ctr + 2'd1;
            end
        end else begin
            if (i_ctr != CTR_STRONG_NOT) begin
                ctr_next = i_ctr - 2'd1;
            end
        end
    end

    // update item write-back
    always_comb begin
        o_update.btb_we            = is_branch_op(i_item.opcode);
        o_update.btb_wdata.valid   = 1'b1;
        o_update.btb_wdata.tag     = i_item.pc;
        o_update.btb_wdata.is_cond = cond;
        if (i_item.branch_taken) begin
            o_update.btb_wdata.target = i_item.actual_next_pc;
        end else if (!i_entry.valid) begin
            o_update.btb_wdata.target = seq_pc;
        end else begin
            o_update.btb_wdata.target = i_entry.target;
        end
        o_update.ctr_we     = cond;
        o_update.ctr_wdata  = ctr_next;
        o_update.hist_shift = cond;
        o_update.hist_bit   = i_item.branch_taken;
    end

endmodule

// ===== design/gshare_btb_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// gshare_btb_branch_predictor
// Direct-mapped branch target buffer plus gshare table of 2-bit counters.
//
//   channel   ports                       handshake
//   input     i_item (t_in_item)          accepted when start && !busy
//   result    o_result (t_out_item)       one cycle strobe o_valid
//
// The accept edge reads both memories and moves to ST_EXEC, which resolves,
// drives the result (predict) and writes back (update). busy is high in
// ST_EXEC, so a new item is not accepted until the last one is through.
// After reset a clearing pass over CLEAR_ENTRIES (1024) addresses writes zero
// to every entry, with busy high. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module gshare_btb_branch_predictor
    import gsbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [CLR_W-1:0]        r_clr_addr;
    logic [HISTORY_BITS-1:0] r_hist;
    t_in_item                r_item;
    logic [TGT_IDX_W-1:0]    r_tidx;
    logic [CTR_IDX_W-1:0]    r_cidx;

    logic                 accept;
    logic [63:0]          mixed;
    logic [TGT_IDX_W-1:0] tidx;
    logic [CTR_IDX_W-1:0] cidx;
    t_btb_entry           btb_rdata;
    t_ctr                 ctr_rdata;
    t_update              upd;
    logic                 exec_update;

    logic                 btb_we;
    logic [TGT_IDX_W-1:0] btb_waddr;
    t_btb_entry           btb_wdata;
    logic                 ctr_we;
    logic [CTR_IDX_W-1:0] ctr_waddr;
    t_ctr                 ctr_wdata;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // table indexes from the incoming item
    assign mixed = {{(64 - HISTORY_BITS){1'b0}}, r_hist} ^ {2'b00, i_item.pc[63:2]};
    assign tidx  = i_item.pc[TGT_IDX_W+1:2];
    assign cidx  = mixed[CTR_IDX_W-1:0];

    // control state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_W'(CLEAR_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + CLR_W'(1);
            end
        end
    end

    // global history shifts on a conditional update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (exec_update && upd.hist_shift) begin
            r_hist <= {r_hist[HISTORY_BITS-2:0], upd.hist_bit};
        end
    end

    // item and index capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_tidx <= tidx;
            r_cidx <= cidx;
        end
    end

    assign exec_update = (r_state == ST_EXEC) && (r_item.kind == KIND_UPDATE);

    // write port muxing: clearing pass or write-back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            btb_we    = 1'b1;
            btb_waddr = r_clr_addr[TGT_IDX_W-1:0];
            btb_wdata = '0;
            ctr_we    = 1'b1;
            ctr_waddr = r_clr_addr[CTR_IDX_W-1:0];
            ctr_wdata = CTR_STRONG_NOT;
        end else begin
            btb_we    = exec_update && upd.btb_we;
            btb_waddr = r_tidx;
            btb_wdata = upd.btb_wdata;
            ctr_we    = exec_update && upd.ctr_we;
            ctr_waddr = r_cidx;
            ctr_wdata = upd.ctr_wdata;
        end
    end

    // target buffer memory
    gsbp_ram #(
        .WIDTH ($bits(t_btb_entry)),
        .DEPTH (TARGET_ENTRIES)
    ) u_btb (
        .i_clk   (i_clk),
        .i_we    (btb_we),
        .i_waddr (btb_waddr),
        .i_wdata (btb_wdata),
        .i_re    (accept),
        .i_raddr (tidx),
        .o_rdata (btb_rdata)
    );

    // direction counter memory
    gsbp_ram #(
        .WIDTH ($bits(t_ctr)),
        .DEPTH (COUNTER_ENTRIES)
    ) u_ctr (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (ctr_waddr),
        .i_wdata (ctr_wdata),
        .i_re    (accept),
        .i_raddr (cidx),
        .o_rdata (ctr_rdata)
    );

    // prediction and write-back values
    gsbp_resolve u_resolve (
        .i_item   (r_item),
        .i_entry  (btb_rdata),
        .i_ctr    (ctr_rdata),
        .o_result (o_result),
        .o_update (upd)
    );

    // result strobe for predict items
    assign o_valid = (r_state == ST_EXEC) && (r_item.kind == KIND_PREDICT);

    // checks
    a_valid_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy))
        else $error("result strobe without an accepted item");

    a_accept_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_EXEC))
        else $error("accepted item did not start execution");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_IDLE))
        else $error("execution lasted more than one cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (btb_we || ctr_we) |-> (r_state != ST_IDLE))
        else $error("memory write while idle");

endmodule

// ===== tb/gshare_btb_branch_predictor_tb.sv =====
// ----------------------------------------------------------------------------
// gshare_btb_branch_predictor_tb
// Self-checking bench for the gshare / BTB branch predictor. A driver feeds
// predict and update items from a queue with random gaps between them. A
// scoreboard model of the target buffer, direction counters and global history
// computes the next pc and miss flag of every predict item. A monitor compares
// each result strobe against the oldest expected result.
// ----------------------------------------------------------------------------
module gshare_btb_branch_predictor_tb;
    import gsbp_pkg::*;

    // one queued item plus the idle cycles in front of it
    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_stim;

    // branch site used by the random part
    typedef struct {
        logic [63:0] pc;
        logic [63:0] target;
        logic        bias;
    } t_site;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    gshare_btb_branch_predictor u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // scoreboard copy of the predictor state
    logic [HISTORY_BITS-1:0] hist_m;
    logic [1:0]              ctr_m        [COUNTER_ENTRIES];
    logic                    btb_valid_m  [TARGET_ENTRIES];
    logic [63:0]             btb_tag_m    [TARGET_ENTRIES];
    logic                    btb_cond_m   [TARGET_ENTRIES];
    logic [63:0]             btb_target_m [TARGET_ENTRIES];

    t_stim       stim_q[$];
    t_out_item   fetch_result_q[$];
    int unsigned hold_cnt;
    int unsigned n_err;
    int unsigned n_predict;
    int unsigned n_hit;
    int unsigned n_update;
    int unsigned n_nonbranch;

    function automatic logic cond_branch(logic [10:0] op);
        case (op)
            OP_CBZ, OP_CBNZ, OP_BCOND: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic any_branch(logic [10:0] op);
        return cond_branch(op) || op == OP_B || op == OP_BR;
    endfunction

    function automatic int unsigned btb_slot(logic [63:0] pc);
        return int'((pc >> 2) % TARGET_ENTRIES);
    endfunction

    function automatic int unsigned ctr_slot(logic [63:0] pc);
        logic [63:0] mixed;
        mixed = {{(64-HISTORY_BITS){1'b0}}, hist_m} ^ (pc >> 2);
        return int'(mixed % COUNTER_ENTRIES);
    endfunction

    // clear all model tables
    task automatic clear_tables();
        hist_m = '0;
        foreach (ctr_m[k]) ctr_m[k] = CTR_STRONG_NOT;
        for (int k = 0; k < TARGET_ENTRIES; k++) begin
            btb_valid_m[k]  = 1'b0;
            btb_tag_m[k]    = '0;
            btb_cond_m[k]   = 1'b0;
            btb_target_m[k] = '0;
        end
    endtask

    // apply one accepted item: predict queues a result, update trains the tables
    task automatic track_item(t_in_item it);
        int unsigned t;
        int unsigned c;
        t_out_item   res;
        t = btb_slot(it.pc);
        c = ctr_slot(it.pc);
        if (it.kind == KIND_PREDICT) begin
            res.next_pc  = it.pc + 64'd4;
            res.btb_miss = 1'b1;
            if (btb_valid_m[t] && btb_tag_m[t] == it.pc) begin
                res.btb_miss = 1'b0;
                if (!btb_cond_m[t] || ctr_m[c] >= 2'd2) res.next_pc = btb_target_m[t];
                n_hit++;
            end
            fetch_result_q.push_back(res);
            n_predict++;
        end else begin
            n_update++;
            if (!any_branch(it.opcode)) n_nonbranch++;
            if (any_branch(it.opcode)) begin
                btb_tag_m[t]  = it.pc;
                btb_cond_m[t] = cond_branch(it.opcode);
                if (it.branch_taken) btb_target_m[t] = it.actual_next_pc;
                else if (!btb_valid_m[t]) btb_target_m[t] = it.pc + 64'd4;
                btb_valid_m[t] = 1'b1;
            end
            // counter index was taken before the history shift
            if (cond_branch(it.opcode)) begin
                if (it.branch_taken && ctr_m[c] != CTR_STRONG_TAKEN) ctr_m[c]++;
                else if (!it.branch_taken && ctr_m[c] != CTR_STRONG_NOT) ctr_m[c]--;
                hist_m = {hist_m[HISTORY_BITS-2:0], it.branch_taken};
            end
        end
    endtask

    // driver: present queued items, hold each until accepted
    always @(posedge i_clk) begin
        logic go;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
            clear_tables();
            hold_cnt = 0;
        end else begin
            go = start;
            if (start && !busy) begin
                track_item(i_item);
                go = 1'b0;
            end
            if (!go && stim_q.size() != 0) begin
                if (hold_cnt < stim_q[0].gap) begin
                    hold_cnt++;
                end else begin
                    i_item <= stim_q[0].item;
                    void'(stim_q.pop_front());
                    go       = 1'b1;
                    hold_cnt = 0;
                end
            end
            start <= go;
        end
    end

    // monitor: compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (fetch_result_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result next_pc=%h btb_miss=%b", $time,
                         o_result.next_pc, o_result.btb_miss);
            end else begin
                want = fetch_result_q.pop_front();
                if (o_result.next_pc !== want.next_pc) begin
                    n_err++;
                    $display("%0t: next_pc expected %h actual %h", $time,
                             want.next_pc, o_result.next_pc);
                end
                if (o_result.btb_miss !== want.btb_miss) begin
                    n_err++;
                    $display("%0t: btb_miss expected %b actual %b", $time,
                             want.btb_miss, o_result.btb_miss);
                end
            end
        end
    end

    task automatic queue_item(logic kind, logic [63:0] pc, logic [63:0] act, logic tkn,
                              logic [10:0] op, int unsigned gap);
        t_stim s;
        s.item.kind           = kind;
        s.item.pc             = pc;
        s.item.actual_next_pc = act;
        s.item.branch_taken   = tkn;
        s.item.opcode         = op;
        s.gap                 = gap;
        stim_q.push_back(s);
    endtask

    // stimulus, end of run and verdict
    initial begin
        t_site                   sites[48];
        logic [HISTORY_BITS-1:0] hist_d;
        logic [63:0]             pc;
        logic [63:0]             act;
        logic [10:0]             op;
        logic                    tkn;
        logic                    kind;
        int unsigned             sel;
        int unsigned             gap_mode;
        int unsigned             wait_cnt;
        logic [10:0]             ops[5];

        n_err       = 0;
        n_predict   = 0;
        n_hit       = 0;
        n_update    = 0;
        n_nonbranch = 0;
        ops = '{OP_CBZ, OP_CBNZ, OP_BCOND, OP_B, OP_BR};

        // directed: address extremes and ignored fields on predict
        queue_item(KIND_PREDICT, '0, '0, 1'b0, 11'h000, 0);
        queue_item(KIND_PREDICT, '1, '1, 1'b1, 11'h7FF, $urandom_range(0, 13));
        // non-branch update leaves the buffer alone
        queue_item(KIND_UPDATE, 64'h1000, 64'h8000, 1'b1, 11'h000, 0);
        queue_item(KIND_PREDICT, 64'h1000, '0, 1'b0, 11'h000, 0);
        // fresh entry taken, then a hit and an alias with another tag
        queue_item(KIND_UPDATE, 64'h1000, 64'hDEAD_BEEF_0000_0040, 1'b1, OP_B, 1);
        queue_item(KIND_PREDICT, 64'h1000, '0, 1'b0, 11'h000, 0);
        queue_item(KIND_PREDICT, 64'h1000 + TARGET_ENTRIES * 4, '0, 1'b0, 11'h000, 3);
        // fresh entry not taken falls through to pc + 4
        queue_item(KIND_UPDATE, 64'h2000, 64'h5555_5555_5555_5555, 1'b0, OP_BR, 0);
        queue_item(KIND_PREDICT, 64'h2000, '0, 1'b0, 11'h000, 2);
        // valid entry not taken keeps its target
        queue_item(KIND_UPDATE, 64'h2000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, OP_BR, 0);
        queue_item(KIND_UPDATE, 64'h2000, 64'h1234, 1'b0, OP_B, 5);
        queue_item(KIND_PREDICT, 64'h2000, '0, 1'b0, 11'h000, 0);

        // drive one counter up past strongly taken and back past strongly not
        hist_d = '0;
        for (int k = 0; k < 10; k++) begin
            tkn = (k < 5);
            pc  = 64'h4_0000 | (64'((hist_d ^ 8'h5A) % COUNTER_ENTRIES) << 2);
            queue_item(KIND_UPDATE, pc, 64'h9000 + k * 16, tkn, ops[k % 3],
                       $urandom_range(0, 13));
            hist_d = {hist_d[HISTORY_BITS-2:0], tkn};
            if (k == 4 || k == 9)
                queue_item(KIND_PREDICT, pc, '0, 1'b0, 11'h000, 0);
        end
        // all-ones pc with a wrapping target
        queue_item(KIND_UPDATE, '1, '0, 1'b1, OP_B, 1);
        queue_item(KIND_PREDICT, '1, '0, 1'b0, 11'h000, 0);

        // branch sites; odd sites alias the buffer slot of the one before
        for (int k = 0; k < 48; k++) begin
            if (k % 2 == 1)
                sites[k].pc = sites[k-1].pc ^ (64'h1 << $urandom_range(12, 63));
            else
                sites[k].pc = {$urandom, $urandom};
            sites[k].target = {$urandom, $urandom};
            sites[k].bias   = 1'($urandom_range(0, 1));
        end

        // random part: mostly known branch sites, some noise
        gap_mode = 0;
        for (int n = 0; n < 1200; n++) begin
            if (n % 50 == 0) gap_mode = $urandom_range(0, 3);
            sel  = $urandom_range(0, 47);
            kind = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 80) begin
                pc  = sites[sel].pc;
                act = ($urandom_range(0, 3) != 0) ? sites[sel].target : {$urandom, $urandom};
                tkn = ($urandom_range(0, 7) != 0) ? sites[sel].bias : !sites[sel].bias;
            end else begin
                pc  = {$urandom, $urandom};
                act = {$urandom, $urandom};
                tkn = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < 85) op = ops[$urandom_range(0, 4)];
            else op = 11'($urandom_range(0, 2047));
            queue_item(kind, pc, act, tkn, op, (gap_mode == 0) ? 0 : $urandom_range(0, 13));
        end

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all items accepted, then all results back, then a few spare cycles
        while (stim_q.size() != 0 || start) @(posedge i_clk);
        wait_cnt = 0;
        while (fetch_result_q.size() != 0 && wait_cnt < 200) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (10) @(posedge i_clk);
        if (fetch_result_q.size() != 0) begin
            n_err += fetch_result_q.size();
            $display("%0t: %0d expected results never arrived", $time, fetch_result_q.size());
        end

        $display("covered %0d predicts (%0d buffer hits) and %0d updates (%0d non-branch)",
                 n_predict, n_hit, n_update, n_nonbranch);
        $display("errors found: %0d", n_err);
        if (n_err == 0)
            $display("gshare_btb_branch_predictor: match");
        else
            $display("gshare_btb_branch_predictor: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("timeout at %0t", $time);
        $display("gshare_btb_branch_predictor: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gsbp_pkg.sv
design/gsbp_ram.sv
design/gsbp_resolve.sv
design/gshare_btb_branch_predictor.sv
tb/gshare_btb_branch_predictor_tb.sv
